/* sv/rmlr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line raster package
// Shared constants, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rmlr_pkg;

    localparam int GRID_SIZE   = 32;
    localparam int STACK_DEPTH = 8;
    localparam int COORD_W     = 5;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } req_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } pix_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        point_t a;
        point_t b;
    } segment_t;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic emit;
        logic emit_sel_b;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic leaf;
        logic stack_empty;
    } dp_status_t;

    typedef struct packed {
        logic emit_ok;
        logic flush_ok;
    } out_status_t;

    // Coordinates at or beyond the grid edge saturate to the last column or row.
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] c;
        c = v;
        if ({1'b0, v} >= (COORD_W+1)'(GRID_SIZE))
        begin
            c = COORD_W'(GRID_SIZE - 1);
        end
        return c;
    endfunction

endpackage

/* sv/rmlr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line raster datapath
// Current segment, midpoint split and the pending segment stack.
// ----------------------------------------------------------------------------
module rmlr_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmlr_pkg::req_item_t  req,
    input  rmlr_pkg::ctrl_cmd_t  cmd,
    output rmlr_pkg::dp_status_t status,
    output rmlr_pkg::point_t     cand
);

    rmlr_pkg::segment_t               seg_reg, seg_next;
    logic [rmlr_pkg::SP_W-1:0]        sp_reg, sp_next;
    rmlr_pkg::segment_t               stack_mem [rmlr_pkg::STACK_DEPTH];

    logic [rmlr_pkg::COORD_W-1:0]     dx, dy, span;
    logic [rmlr_pkg::COORD_W:0]       sum_x, sum_y;
    rmlr_pkg::point_t                 mid;
    logic [rmlr_pkg::SP_W-1:0]        sp_dec;
    logic                             stack_full;

    always_comb
    begin
        dx = (seg_reg.a.x > seg_reg.b.x) ? (seg_reg.a.x - seg_reg.b.x)
                                          : (seg_reg.b.x - seg_reg.a.x);
        dy = (seg_reg.a.y > seg_reg.b.y) ? (seg_reg.a.y - seg_reg.b.y)
                                          : (seg_reg.b.y - seg_reg.a.y);
        span  = (dx > dy) ? dx : dy;
        sum_x = {1'b0, seg_reg.a.x} + {1'b0, seg_reg.b.x};
        sum_y = {1'b0, seg_reg.a.y} + {1'b0, seg_reg.b.y};
        mid.x = sum_x[rmlr_pkg::COORD_W:1];
        mid.y = sum_y[rmlr_pkg::COORD_W:1];
        sp_dec     = sp_reg - 1'b1;
        stack_full = (sp_reg == rmlr_pkg::SP_W'(rmlr_pkg::STACK_DEPTH));
    end

    // A segment with coincident endpoints is a leaf too; the duplicate
    // second pixel is dropped downstream.
    assign status.leaf        = (span <= rmlr_pkg::COORD_W'(1)) || stack_full;
    assign status.stack_empty = (sp_reg == '0);
    assign cand = cmd.emit_sel_b ? seg_reg.b : seg_reg.a;

    always_comb
    begin
        seg_next = seg_reg;
        sp_next  = sp_reg;
        priority if (cmd.load)
        begin
            seg_next.a.x = rmlr_pkg::clamp_coord(req.start_x);
            seg_next.a.y = rmlr_pkg::clamp_coord(req.start_y);
            seg_next.b.x = rmlr_pkg::clamp_coord(req.end_x);
            seg_next.b.y = rmlr_pkg::clamp_coord(req.end_y);
            sp_next      = '0;
        end
        else if (cmd.push)
        begin
            seg_next.b = mid;
            sp_next    = sp_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            sp_next  = sp_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    // The popped segment is read straight from the stack into the segment register.
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            seg_reg <= stack_mem[sp_dec[rmlr_pkg::IDX_W-1:0]];
        end
        else
        begin
            seg_reg <= seg_next;
        end
        if (cmd.push)
        begin
            stack_mem[sp_reg[rmlr_pkg::IDX_W-1:0]] <= '{a: mid, b: seg_reg.b};
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= rmlr_pkg::SP_W'(rmlr_pkg::STACK_DEPTH))
        else $error("segment stack pointer beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stack_full)
        else $error("push onto a full segment stack");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (sp_reg != '0))
        else $error("pop from an empty segment stack");

endmodule

/* sv/rmlr_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line raster output stage
// Drops repeated pixels, holds one pixel back to flag the last, output register.
// ----------------------------------------------------------------------------
module rmlr_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmlr_pkg::ctrl_cmd_t   cmd,
    input  rmlr_pkg::point_t      cand,
    output rmlr_pkg::out_status_t status,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output rmlr_pkg::pix_item_t   pix
);

    logic                 pend_valid_reg, pend_valid_next;
    rmlr_pkg::point_t     pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    rmlr_pkg::pix_item_t  out_reg, out_next;
    logic                 out_free;
    logic                 is_new;

    assign out_free        = !out_valid_reg || pix_ready;
    assign is_new          = pend_valid_reg && (cand != pend_reg);
    assign status.emit_ok  = !is_new || out_free;
    assign status.flush_ok = out_free;
    assign pix_valid       = out_valid_reg;
    assign pix             = out_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !pix_ready;
        out_next        = out_reg;
        if (cmd.emit)
        begin
            if (!pend_valid_reg)
            begin
                pend_valid_next = 1'b1;
                pend_next       = cand;
            end
            else if (is_new && out_free)
            begin
                // A different pixel arrives, so the held one is not the last.
                out_valid_next = 1'b1;
                out_next       = '{pixel_x: pend_reg.x, pixel_y: pend_reg.y,
                                   last_pixel: 1'b0};
                pend_next      = cand;
            end
        end
        else if (cmd.flush && out_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = '{pixel_x: pend_reg.x, pixel_y: pend_reg.y,
                                last_pixel: 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush && out_free |=> !pend_valid_reg && out_valid_reg && out_reg.last_pixel)
        else $error("flush did not deliver a last pixel");

endmodule

/* sv/rmlr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line raster controller
// Sequences load, split, leaf painting, stack pop and the final flush.
// ----------------------------------------------------------------------------
module rmlr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  rmlr_pkg::dp_status_t  dp_status,
    input  rmlr_pkg::out_status_t out_status,
    output rmlr_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_LEAF_B = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (dp_status.leaf)
                begin
                    cmd.emit = 1'b1;
                    if (out_status.emit_ok)
                    begin
                        state_next = ST_LEAF_B;
                    end
                end
                else
                begin
                    cmd.push = 1'b1;
                end
            end
            ST_LEAF_B:
            begin
                cmd.emit       = 1'b1;
                cmd.emit_sel_b = 1'b1;
                if (out_status.emit_ok)
                begin
                    if (dp_status.stack_empty)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (out_status.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/recursive_midpoint_line_raster_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive midpoint line raster unit
// Turns a two-endpoint line request into the pixels of midpoint subdivision.
// ----------------------------------------------------------------------------
// One request is taken only while the unit is idle. The line is split at the
// floored midpoint until its segments have adjacent endpoints; each such leaf
// paints both endpoints, repeated pixels are dropped and the final pixel is
// marked with last_pixel. The sequencer takes the request, then splits the
// segment at hand or paints the two endpoints of a leaf segment in turn, and
// at the end releases the last pixel.
// Output stalls hold the sequencer only when a new pixel has to leave.
module recursive_midpoint_line_raster_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rmlr_pkg::req_item_t req,
    output logic                pix_valid,
    input  logic                pix_ready,
    output rmlr_pkg::pix_item_t pix
);

    rmlr_pkg::ctrl_cmd_t   cmd;
    rmlr_pkg::dp_status_t  dp_status;
    rmlr_pkg::out_status_t out_status;
    rmlr_pkg::point_t      cand;

    rmlr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .dp_status  (dp_status),
        .out_status (out_status),
        .cmd        (cmd)
    );

    rmlr_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (dp_status),
        .cand   (cand)
    );

    rmlr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cand      (cand),
        .status    (out_status),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

endmodule

/* bench/recursive_midpoint_line_raster_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line raster unit testbench
// Sends line requests over the request channel and checks every pixel that
// comes back against typed pixels or a midpoint subdivision predictor. A
// short directed list of lines comes first, followed by random lines. Both
// channels see random gaps, the output is held off once for a long stretch,
// and the sender drains the unit once partway through.
// ----------------------------------------------------------------------------
module recursive_midpoint_line_raster_unit_tb;

    localparam int MAX_PIXELS   = 63;
    localparam int RANDOM_LINES = 90;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int IDLE_LIMIT   = 3000;

    typedef struct {
        rmlr_pkg::req_item_t rq;
        int                  n_typed;
        rmlr_pkg::pix_item_t first_px;
        rmlr_pkg::pix_item_t second_px;
    } line_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    rmlr_pkg::req_item_t req;
    logic                pix_valid;
    logic                pix_ready;
    rmlr_pkg::pix_item_t pix;

    rmlr_pkg::pix_item_t pixels_due[$];
    rmlr_pkg::pix_item_t line_buf[$];
    rmlr_pkg::point_t    prev_pt;
    line_row_t           directed_rows[$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    bit                  long_hold_due = 1'b0;

    recursive_midpoint_line_raster_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [rmlr_pkg::COORD_W-1:0] saturate(
        input logic [rmlr_pkg::COORD_W-1:0] v);
        logic [rmlr_pkg::COORD_W-1:0] c;
        c = v;
        if (int'(v) >= rmlr_pkg::GRID_SIZE)
        begin
            c = rmlr_pkg::COORD_W'(rmlr_pkg::GRID_SIZE - 1);
        end
        return c;
    endfunction

    // The first pixel of a line always goes out; later repeats of the
    // previous pixel are dropped.
    function automatic void add_point(input rmlr_pkg::point_t p);
        rmlr_pkg::pix_item_t px;
        if (line_buf.size() > 0 && p == prev_pt)
        begin
            return;
        end
        if (line_buf.size() >= MAX_PIXELS)
        begin
            return;
        end
        px.pixel_x    = p.x;
        px.pixel_y    = p.y;
        px.last_pixel = 1'b0;
        line_buf.push_back(px);
        prev_pt = p;
    endfunction

    function automatic void paint_line(input rmlr_pkg::req_item_t r);
        rmlr_pkg::segment_t           pending[rmlr_pkg::STACK_DEPTH];
        int                           depth;
        int                           dx;
        int                           dy;
        bit                           done;
        rmlr_pkg::point_t             a;
        rmlr_pkg::point_t             b;
        rmlr_pkg::point_t             mid;
        rmlr_pkg::pix_item_t          tail;
        logic [rmlr_pkg::COORD_W:0]   sum;
        a.x = saturate(r.start_x);
        a.y = saturate(r.start_y);
        b.x = saturate(r.end_x);
        b.y = saturate(r.end_y);
        depth = 0;
        line_buf.delete();
        if (a == b)
        begin
            add_point(a);
        end
        else
        begin
            done = 1'b0;
            while (!done)
            begin
                dx = (a.x > b.x) ? int'(a.x) - int'(b.x) : int'(b.x) - int'(a.x);
                dy = (a.y > b.y) ? int'(a.y) - int'(b.y) : int'(b.y) - int'(a.y);
                if ((dx <= 1 && dy <= 1) || depth >= rmlr_pkg::STACK_DEPTH)
                begin
                    add_point(a);
                    add_point(b);
                    if (depth == 0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        depth--;
                        a = pending[depth].a;
                        b = pending[depth].b;
                    end
                end
                else
                begin
                    sum   = {1'b0, a.x} + {1'b0, b.x};
                    mid.x = sum[rmlr_pkg::COORD_W:1];
                    sum   = {1'b0, a.y} + {1'b0, b.y};
                    mid.y = sum[rmlr_pkg::COORD_W:1];
                    pending[depth].a = mid;
                    pending[depth].b = b;
                    depth++;
                    b = mid;
                end
            end
        end
        tail = line_buf.pop_back();
        tail.last_pixel = 1'b1;
        line_buf.push_back(tail);
        foreach (line_buf[i])
        begin
            pixels_due.push_back(line_buf[i]);
        end
    endfunction

    function automatic void add_row(input int sx, input int sy, input int ex, input int ey,
                                    input int n, input int x0, input int y0,
                                    input int x1, input int y1);
        line_row_t row;
        row.rq        = '{rmlr_pkg::COORD_W'(sx), rmlr_pkg::COORD_W'(sy),
                          rmlr_pkg::COORD_W'(ex), rmlr_pkg::COORD_W'(ey)};
        row.n_typed   = n;
        row.first_px  = '{rmlr_pkg::COORD_W'(x0), rmlr_pkg::COORD_W'(y0), (n == 1)};
        row.second_px = '{rmlr_pkg::COORD_W'(x1), rmlr_pkg::COORD_W'(y1), 1'b1};
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_near(input int c, input int span);
        int v;
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > rmlr_pkg::GRID_SIZE - 1)
        begin
            v = rmlr_pkg::GRID_SIZE - 1;
        end
        return v;
    endfunction

    // Drives one request after a random gap and returns at the edge where
    // the transfer happens.
    task automatic offer_request(input rmlr_pkg::req_item_t r);
        int pick;
        int gap;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            gap = 0;
        end
        else if (pick < 9)
        begin
            gap = $urandom_range(1, 4);
        end
        else
        begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic rmlr_pkg::req_item_t random_line();
        rmlr_pkg::req_item_t r;
        int                  kind;
        int                  sx;
        int                  sy;
        kind = $urandom_range(0, 9);
        sx   = $urandom_range(0, rmlr_pkg::GRID_SIZE - 1);
        sy   = $urandom_range(0, rmlr_pkg::GRID_SIZE - 1);
        r.start_x = rmlr_pkg::COORD_W'(sx);
        r.start_y = rmlr_pkg::COORD_W'(sy);
        if (kind == 0)
        begin
            r.end_x = rmlr_pkg::COORD_W'(sx);
            r.end_y = rmlr_pkg::COORD_W'(sy);
        end
        else if (kind < 3)
        begin
            r.end_x = rmlr_pkg::COORD_W'(pick_near(sx, 1));
            r.end_y = rmlr_pkg::COORD_W'(pick_near(sy, 1));
        end
        else if (kind < 7)
        begin
            r.end_x = rmlr_pkg::COORD_W'(pick_near(sx, 6));
            r.end_y = rmlr_pkg::COORD_W'(pick_near(sy, 6));
        end
        else
        begin
            r.end_x = rmlr_pkg::COORD_W'($urandom_range(0, rmlr_pkg::GRID_SIZE - 1));
            r.end_y = rmlr_pkg::COORD_W'($urandom_range(0, rmlr_pkg::GRID_SIZE - 1));
        end
        return r;
    endfunction

    // Output side: ready in runs of random length with short and long gaps,
    // plus one long hold-off when the stimulus asks for it.
    initial
    begin : output_side
        int pick;
        int run;
        int gap;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            run = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            pix_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                pix_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                begin
                    gap = 0;
                end
                else if (pick < 9)
                begin
                    gap = $urandom_range(1, 5);
                end
                else
                begin
                    gap = $urandom_range(20, 80);
                end
                if (gap > 0)
                begin
                    pix_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_pixels
        rmlr_pkg::pix_item_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (pixels_due.size() == 0)
            begin
                report_mismatch($sformatf("pixel (%0d,%0d) last=%0b with none expected",
                                          pix.pixel_x, pix.pixel_y, pix.last_pixel));
            end
            else
            begin
                want = pixels_due.pop_front();
                if (pix.pixel_x !== want.pixel_x)
                begin
                    report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                              pix.pixel_x, want.pixel_x));
                end
                if (pix.pixel_y !== want.pixel_y)
                begin
                    report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                              pix.pixel_y, want.pixel_y));
                end
                if (pix.last_pixel !== want.last_pixel)
                begin
                    report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                              pix.last_pixel, want.last_pixel));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (pix_valid && pix_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rmlr_pkg::req_item_t r;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        pix_ready <= 1'b0;
        prev_pt   = '0;

        // Single-pixel lines, adjacent pairs and the grid corners are typed in.
        add_row(0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(31, 31, 31, 31, 1, 31, 31, 0, 0);
        add_row(0, 0, 1, 0, 2, 0, 0, 1, 0);
        add_row(31, 31, 30, 30, 2, 31, 31, 30, 30);
        add_row(0, 31, 1, 30, 2, 0, 31, 1, 30);
        add_row(0, 0, 31, 31, 0, 0, 0, 0, 0);
        add_row(31, 0, 0, 31, 0, 0, 0, 0, 0);
        add_row(0, 31, 31, 0, 0, 0, 0, 0, 0);
        add_row(31, 31, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 31, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 31, 0, 0, 0, 0, 0);
        // Starts on the pixel the previous line ended on.
        add_row(0, 31, 0, 31, 1, 0, 31, 0, 0);
        add_row(0, 31, 2, 31, 0, 0, 0, 0, 0);
        add_row(2, 31, 2, 31, 1, 2, 31, 0, 0);
        add_row(31, 0, 31, 31, 0, 0, 0, 0, 0);
        add_row(16, 16, 17, 15, 2, 16, 16, 17, 15);
        add_row(10, 3, 27, 19, 0, 0, 0, 0, 0);
        add_row(1, 30, 30, 2, 0, 0, 0, 0, 0);
        add_row(7, 0, 8, 31, 0, 0, 0, 0, 0);
        add_row(21, 10, 5, 26, 0, 0, 0, 0, 0);
        add_row(3, 3, 5, 4, 0, 0, 0, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i].rq);
            if (directed_rows[i].n_typed == 0)
            begin
                paint_line(directed_rows[i].rq);
            end
            else
            begin
                pixels_due.push_back(directed_rows[i].first_px);
                if (directed_rows[i].n_typed == 2)
                begin
                    pixels_due.push_back(directed_rows[i].second_px);
                end
            end
        end

        for (int n = 0; n < RANDOM_LINES; n++)
        begin
            if (n == 30)
            begin
                long_hold_due = 1'b1;
            end
            if (n == 75)
            begin
                // Let the unit drain completely before the next request.
                req_valid <= 1'b0;
                @(posedge clk);
                while (pixels_due.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            r = random_line();
            offer_request(r);
            paint_line(r);
        end
        req_valid <= 1'b0;

        while (pixels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pixels_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d pixels never arrived", pixels_due.size()));
        end

        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
